@@ rtl/core/sft_pkg.sv @@
// ----------------------------------------------------------------------------
// sft_pkg
// Shared types and constants of the spherical flip transform: field widths,
// operation and status codes, controller states and the command and status
// words between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sft_pkg;

	localparam int COORD_W    = 24;
	localparam int NORM_W     = 32;
	localparam int GAIN_W     = 32;
	localparam int RADIUS_W   = 48;
	localparam int OUT_W      = 56;
	localparam int SQ_W       = 48;
	localparam int RAD_W      = 64;
	localparam int DIFF_W     = 50;
	localparam int HALF_W     = 25;
	localparam int AMAG_W     = 32;
	localparam int PLO_W      = 57;
	localparam int PROD_W     = 82;
	localparam int QUO_W      = 56;
	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS  = 56;
	localparam int CNT_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int STATUS_W   = 2;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 32'h0001_0000;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_Z = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_ZERO_DIST = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NO_RADIUS = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd3;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_FLIP  = 2'd1,
		OP_XFORM = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		RK_FLIP,
		RK_ORIGIN,
		RK_EXHAUSTED,
		RK_NO_RADIUS
	} res_kind_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_SQX,
		S_SQY,
		S_SQZ,
		S_SQRT_INIT,
		S_SQRT,
		S_NORM,
		S_STORE,
		S_PICK,
		S_RDATA,
		S_MUL0,
		S_MUL1,
		S_MUL2,
		S_DIV_INIT,
		S_DIV,
		S_OUT
	} state_t;

	typedef struct packed {
		logic      accept;
		logic      load_begin;
		logic      flip_begin;
		logic      sq_en;
		logic      sq_first;
		logic [1:0] sq_axis;
		logic      sqrt_init;
		logic      sqrt_step;
		logic      take_norm;
		logic      store;
		logic      pick_point;
		logic      take_mem;
		logic      mul0;
		logic      mul1;
		logic      mul2;
		logic      div_init;
		logic      div_step;
		logic      set_kind;
		res_kind_t kind;
		logic      out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic emitting;
		logic radius_valid;
		logic load_full;
		logic ptr_lt;
		logic origin_due;
		logic out_free;
	} sts_t;

	// point minus viewpoint, saturated to the coordinate width
	function automatic logic signed [COORD_W-1:0] rel_coord(
		input logic signed [COORD_W-1:0] raw,
		input logic signed [COORD_W-1:0] view
	);
		logic signed [COORD_W:0] d;
		d = {raw[COORD_W-1], raw} - {view[COORD_W-1], view};
		if (d[COORD_W] != d[COORD_W-1]) begin
			rel_coord = d[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
		end else begin
			rel_coord = d[COORD_W-1:0];
		end
	endfunction

	function automatic logic [COORD_W-1:0] abs_coord(input logic signed [COORD_W-1:0] v);
		abs_coord = v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/sft_in_if.sv @@
// ----------------------------------------------------------------------------
// sft_in_if
// Input channel: operation word with a world point.
// ----------------------------------------------------------------------------
`default_nettype none

interface sft_in_if import sft_pkg::*;;
	logic                      valid;
	logic                      ready;
	logic [1:0]                operation;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] point_z;

	modport source (output valid, operation, point_x, point_y, point_z, input ready);
	modport sink (input valid, operation, point_x, point_y, point_z, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sft_out_if.sv @@
// ----------------------------------------------------------------------------
// sft_out_if
// Output channel: flipped point with flags and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface sft_out_if import sft_pkg::*;;
	logic                       valid;
	logic                       ready;
	logic signed [OUT_W-1:0]    flipped_x;
	logic signed [OUT_W-1:0]    flipped_y;
	logic signed [OUT_W-1:0]    flipped_z;
	logic                       is_viewpoint;
	logic                       last_of_cloud;
	logic [STATUS_W-1:0]        status;

	modport source (output valid, flipped_x, flipped_y, flipped_z, is_viewpoint,
		last_of_cloud, status, input ready);
	modport sink (input valid, flipped_x, flipped_y, flipped_z, is_viewpoint,
		last_of_cloud, status, output ready);
endinterface

`default_nettype wire

@@ rtl/core/sft_ram.sv @@
// ----------------------------------------------------------------------------
// sft_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [$clog2(DEPTH)-1:0]     waddr,
	input  wire logic [WIDTH-1:0]             wdata,
	input  wire logic                         re,
	input  wire logic [$clog2(DEPTH)-1:0]     raddr,
	output logic [WIDTH-1:0]                  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/sft_ctrl.sv @@
// ----------------------------------------------------------------------------
// sft_ctrl
// Sequencer of the spherical flip transform: walks one word at a time through
// the norm, store, fetch, multiply and divide steps of the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module sft_ctrl import sft_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	output cmd_t      cmd,
	input  wire sts_t sts
);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic              sqrt_last, div_last;

	assign sqrt_last = (cnt_q == CNT_W'(SQRT_STEPS - 1));
	assign div_last  = (cnt_q == CNT_W'(DIV_STEPS - 1));
	assign in_ready  = (state_q == S_IDLE);

	// advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// step counter for the iterative units
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == S_SQRT || state_q == S_DIV) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_DECODE;
			end
			S_DECODE: begin
				case (sts.op)
					OP_LOAD:  state_d = sts.load_full ? S_IDLE : S_SQX;
					OP_FLIP:  state_d = S_PICK;
					OP_XFORM: state_d = sts.radius_valid ? S_SQX : S_OUT;
					default:  state_d = S_IDLE;
				endcase
			end
			S_SQX:       state_d = S_SQY;
			S_SQY:       state_d = S_SQZ;
			S_SQZ:       state_d = S_SQRT_INIT;
			S_SQRT_INIT: state_d = S_SQRT;
			S_SQRT: begin
				if (sqrt_last) state_d = S_NORM;
			end
			S_NORM:      state_d = (sts.op == OP_LOAD) ? S_STORE : S_MUL0;
			S_STORE:     state_d = S_IDLE;
			S_PICK:      state_d = sts.ptr_lt ? S_RDATA : S_OUT;
			S_RDATA:     state_d = S_MUL0;
			S_MUL0:      state_d = S_MUL1;
			S_MUL1:      state_d = S_MUL2;
			S_MUL2:      state_d = S_DIV_INIT;
			S_DIV_INIT:  state_d = S_DIV;
			S_DIV: begin
				if (div_last) state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) state_d = S_IDLE;
			end
			default:     state_d = S_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd      = '0;
		cmd.kind = RK_FLIP;
		case (state_q)
			S_IDLE:   cmd.accept = in_valid;
			S_DECODE: begin
				case (sts.op)
					OP_LOAD: cmd.load_begin = 1'b1;
					OP_FLIP: cmd.flip_begin = 1'b1;
					OP_XFORM: begin
						cmd.set_kind = !sts.radius_valid;
						cmd.kind     = RK_NO_RADIUS;
					end
					default: cmd = '0;
				endcase
			end
			S_SQX: begin
				cmd.sq_en    = 1'b1;
				cmd.sq_first = 1'b1;
				cmd.sq_axis  = 2'd0;
			end
			S_SQY: begin
				cmd.sq_en   = 1'b1;
				cmd.sq_axis = 2'd1;
			end
			S_SQZ: begin
				cmd.sq_en   = 1'b1;
				cmd.sq_axis = 2'd2;
			end
			S_SQRT_INIT: cmd.sqrt_init = 1'b1;
			S_SQRT:      cmd.sqrt_step = 1'b1;
			S_NORM:      cmd.take_norm = 1'b1;
			S_STORE:     cmd.store     = 1'b1;
			S_PICK: begin
				if (sts.ptr_lt) begin
					cmd.pick_point = 1'b1;
				end else begin
					cmd.set_kind = 1'b1;
					cmd.kind     = sts.origin_due ? RK_ORIGIN : RK_EXHAUSTED;
				end
			end
			S_RDATA: cmd.take_mem = 1'b1;
			S_MUL0:  cmd.mul0     = 1'b1;
			S_MUL1:  cmd.mul1     = 1'b1;
			S_MUL2:  cmd.mul2     = 1'b1;
			S_DIV_INIT: begin
				cmd.div_init = 1'b1;
				cmd.set_kind = 1'b1;
				cmd.kind     = RK_FLIP;
			end
			S_DIV:   cmd.div_step = 1'b1;
			S_OUT:   cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/core/sft_dpath.sv @@
// ----------------------------------------------------------------------------
// sft_dpath
// Datapath of the spherical flip transform: configuration registers, point
// store, norm square root, radius, per-axis flip multiply and divide lanes
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sft_dpath import sft_pkg::*; #(
	parameter int MAX_POINTS = 4096
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_DATA_W-1:0]        cfg_data,
	input  wire logic [1:0]                   operation,
	input  wire logic signed [COORD_W-1:0]    point_x,
	input  wire logic signed [COORD_W-1:0]    point_y,
	input  wire logic signed [COORD_W-1:0]    point_z,
	input  wire cmd_t                         cmd,
	output sts_t                              sts,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic signed [OUT_W-1:0]           flipped_x,
	output logic signed [OUT_W-1:0]           flipped_y,
	output logic signed [OUT_W-1:0]           flipped_z,
	output logic                              is_viewpoint,
	output logic                              last_of_cloud,
	output logic [STATUS_W-1:0]               status
);

	localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW    = $clog2(MAX_POINTS + 1);
	localparam int MEM_W = 3 * COORD_W + NORM_W;
	localparam logic [QUO_W-1:0] NEG_LIM = {1'b1, {(QUO_W-1){1'b0}}};
	localparam logic [QUO_W-1:0] POS_LIM = {1'b0, {(QUO_W-1){1'b1}}};

	// configuration
	logic signed [COORD_W-1:0] view_q [3];
	logic [GAIN_W-1:0]         gain_q;

	// control state
	op_t              op_q;
	logic             emitting_q, radius_valid_q, done_q;
	logic [CW-1:0]    count_q, ptr_q;
	logic [NORM_W-1:0]   max_q;
	logic [RADIUS_W-1:0] radius_q;
	res_kind_t        kind_q;

	// operands and iterative units
	logic signed [COORD_W-1:0] p_q [3];
	logic [NORM_W-1:0]   n_q;
	logic [SQ_W-1:0]     sq_q;
	logic [RAD_W-1:0]    rad_q;
	logic [NORM_W+2:0]   rem_q;
	logic [NORM_W-1:0]   root_q;
	logic [DIFF_W-1:0]   b_q;

	// lane registers
	logic [AMAG_W-1:0] a_q    [3];
	logic              neg_q  [3];
	logic [PLO_W-1:0]  plo_q  [3];
	logic [PROD_W-1:0] prod_q [3];
	logic              sat_q  [3];
	logic [NORM_W-1:0] drem_q [3];
	logic [QUO_W-1:0]  dsh_q  [3];
	logic [QUO_W-1:0]  quo_q  [3];

	logic signed [COORD_W-1:0] in_pt  [3];
	logic signed [COORD_W-1:0] mem_pt [3];
	logic [MEM_W-1:0]          rd_data;
	logic [OUT_W-1:0]          lane_res [3];

	logic [COORD_W-1:0]    sq_op;
	logic [SQ_W-1:0]       sq_prod;
	logic [NORM_W+2:0]     rem_sh, trial;
	logic                  rt_ge;
	logic signed [DIFF_W-1:0] d_s;
	logic [2*GAIN_W-1:0]   rad_prod;
	logic [STATUS_W-1:0]   res_st;

	assign in_pt[0]  = point_x;
	assign in_pt[1]  = point_y;
	assign in_pt[2]  = point_z;
	assign mem_pt[0] = rd_data[MEM_W-1 -: COORD_W];
	assign mem_pt[1] = rd_data[MEM_W-COORD_W-1 -: COORD_W];
	assign mem_pt[2] = rd_data[NORM_W +: COORD_W];

	// status toward the controller
	assign sts.op           = op_q;
	assign sts.emitting     = emitting_q;
	assign sts.radius_valid = radius_valid_q;
	assign sts.load_full    = !emitting_q && (count_q == CW'(MAX_POINTS));
	assign sts.ptr_lt       = (ptr_q < count_q);
	assign sts.origin_due   = (ptr_q == count_q) && !done_q;
	assign sts.out_free     = !out_valid || out_ready;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_q[0] <= '0;
			view_q[1] <= '0;
			view_q[2] <= '0;
			gain_q    <= GAIN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_VIEW_X: view_q[0] <= cfg_data[COORD_W-1:0];
				CFG_VIEW_Y: view_q[1] <= cfg_data[COORD_W-1:0];
				CFG_VIEW_Z: view_q[2] <= cfg_data[COORD_W-1:0];
				CFG_GAIN:   gain_q    <= cfg_data[GAIN_W-1:0];
				default:    gain_q    <= gain_q;
			endcase
		end
	end

	assign rad_prod = gain_q * {{(GAIN_W-NORM_W){1'b0}}, max_q};

	// cloud bookkeeping: count, pointer, maximum, radius
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q           <= OP_NOP;
			emitting_q     <= 1'b0;
			radius_valid_q <= 1'b0;
			done_q         <= 1'b0;
			count_q        <= '0;
			ptr_q          <= '0;
			max_q          <= '0;
			radius_q       <= '0;
			kind_q         <= RK_FLIP;
		end else begin
			if (cmd.accept) op_q <= op_t'(operation);
			if (cmd.load_begin && emitting_q) begin
				emitting_q <= 1'b0;
				count_q    <= '0;
				ptr_q      <= '0;
				max_q      <= '0;
				done_q     <= 1'b0;
			end
			if (cmd.flip_begin && !emitting_q) begin
				radius_q       <= rad_prod[2*GAIN_W-1:16];
				radius_valid_q <= 1'b1;
				emitting_q     <= 1'b1;
				ptr_q          <= '0;
				done_q         <= 1'b0;
			end
			if (cmd.store) begin
				count_q <= count_q + CW'(1);
				if (n_q > max_q) max_q <= n_q;
			end
			if (cmd.pick_point) ptr_q <= ptr_q + CW'(1);
			if (cmd.set_kind) begin
				kind_q <= cmd.kind;
				if (cmd.kind == RK_ORIGIN) done_q <= 1'b1;
			end
		end
	end

	// point store: x, y, z and norm in one word
	sft_ram #(
		.WIDTH(MEM_W),
		.DEPTH(MAX_POINTS)
	) u_store (
		.clk  (clk),
		.we   (cmd.store),
		.waddr(count_q[AW-1:0]),
		.wdata({p_q[0], p_q[1], p_q[2], n_q}),
		.re   (cmd.pick_point),
		.raddr(ptr_q[AW-1:0]),
		.rdata(rd_data)
	);

	// sum of squares, one axis a cycle
	always_comb begin
		case (cmd.sq_axis)
			2'd0:    sq_op = abs_coord(p_q[0]);
			2'd1:    sq_op = abs_coord(p_q[1]);
			default: sq_op = abs_coord(p_q[2]);
		endcase
	end
	assign sq_prod = sq_op * sq_op;

	// square root, two radicand bits a cycle
	assign rem_sh = {rem_q[NORM_W:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign rt_ge  = (rem_sh >= trial);

	// 2R - n for the flip factor
	assign d_s = $signed({1'b0, radius_q, 1'b0}) - $signed({{(DIFF_W-NORM_W){1'b0}}, n_q});

	always_ff @(posedge clk) begin
		if (cmd.sq_en) sq_q <= cmd.sq_first ? sq_prod : sq_q + sq_prod;
		if (cmd.sqrt_init) begin
			rad_q  <= {sq_q, {(RAD_W-SQ_W){1'b0}}};
			rem_q  <= '0;
			root_q <= '0;
		end else if (cmd.sqrt_step) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= rt_ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[NORM_W-2:0], rt_ge};
		end
		if (cmd.take_norm) n_q <= root_q;
		else if (cmd.take_mem) n_q <= rd_data[NORM_W-1:0];
		if (cmd.mul0) b_q <= d_s[DIFF_W-1] ? DIFF_W'(-d_s) : DIFF_W'(d_s);
	end

	// per-axis lanes: multiply by |2R - n|, then restoring divide by n
	for (genvar l = 0; l < 3; l++) begin : g_lane
		logic [NORM_W:0]   t;
		logic              ge;
		logic [PLO_W-1:0]  phi;
		logic [QUO_W-1:0]  mag;

		assign t   = {drem_q[l], dsh_q[l][QUO_W-1]};
		assign ge  = (t >= {1'b0, n_q});
		assign phi = a_q[l] * b_q[DIFF_W-1:HALF_W];

		// saturate the quotient and apply the sign
		always_comb begin
			mag = sat_q[l] ? NEG_LIM : quo_q[l];
			if (neg_q[l]) begin
				if (mag > NEG_LIM) mag = NEG_LIM;
				lane_res[l] = OUT_W'(-mag);
			end else begin
				if (mag > POS_LIM) mag = POS_LIM;
				lane_res[l] = OUT_W'(mag);
			end
		end

		always_ff @(posedge clk) begin
			if (cmd.accept) p_q[l] <= rel_coord(in_pt[l], view_q[l]);
			else if (cmd.take_mem) p_q[l] <= mem_pt[l];
			if (cmd.mul0) begin
				a_q[l]   <= {abs_coord(p_q[l]), 8'b0};
				neg_q[l] <= p_q[l][COORD_W-1] ^ d_s[DIFF_W-1];
			end
			if (cmd.mul1) plo_q[l] <= a_q[l] * b_q[HALF_W-1:0];
			if (cmd.mul2) begin
				prod_q[l] <= {{(PROD_W-PLO_W){1'b0}}, plo_q[l]} +
					{phi, {HALF_W{1'b0}}};
			end
			if (cmd.div_init) begin
				sat_q[l]  <= {{(NORM_W-(PROD_W-QUO_W)){1'b0}}, prod_q[l][PROD_W-1:QUO_W]} >= n_q;
				drem_q[l] <= {{(NORM_W-(PROD_W-QUO_W)){1'b0}}, prod_q[l][PROD_W-1:QUO_W]};
				dsh_q[l]  <= prod_q[l][QUO_W-1:0];
				quo_q[l]  <= '0;
			end else if (cmd.div_step) begin
				drem_q[l] <= ge ? NORM_W'(t - {1'b0, n_q}) : t[NORM_W-1:0];
				dsh_q[l]  <= {dsh_q[l][QUO_W-2:0], 1'b0};
				quo_q[l]  <= {quo_q[l][QUO_W-2:0], ge};
			end
		end
	end

	assign res_st = (n_q == '0) ? ST_ZERO_DIST : ST_OK;

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			flipped_x     <= '0;
			flipped_y     <= '0;
			flipped_z     <= '0;
			is_viewpoint  <= 1'b0;
			last_of_cloud <= 1'b0;
			case (kind_q)
				RK_FLIP: begin
					status <= res_st;
					if (res_st == ST_OK) begin
						flipped_x <= lane_res[0];
						flipped_y <= lane_res[1];
						flipped_z <= lane_res[2];
					end
				end
				RK_ORIGIN: begin
					status        <= ST_OK;
					is_viewpoint  <= 1'b1;
					last_of_cloud <= 1'b1;
				end
				RK_EXHAUSTED: status <= ST_EXHAUSTED;
				default:      status <= ST_NO_RADIUS;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/spherical_flip_transform.sv @@
// ----------------------------------------------------------------------------
// spherical_flip_transform
// Spherical flipping of a point cloud around a viewpoint for hidden point
// removal, in fixed point.
// ----------------------------------------------------------------------------
// One word is processed at a time, and the next input word is taken only
// when the controller is back in idle. Each word takes these steps:
// - A load squares the three axes, takes the 32-step square root of the
//   norm at two radicand bits a cycle and stores the point with its norm.
// - A flip of a stored point reads it back, multiplies and runs the 56-step
//   restoring divide. The three axis lanes run side by side.
// - The origin word and the exhausted word go from the pointer check
//   straight to the output register.
// - The no-radius word goes from decode straight to the output register.
// - A transform word runs the square root, then the multiply and the divide.
// A finished word sits in the output register while the next input word is
// taken. A word that finds the output register still full waits in the
// output state while the receiver stalls. The point store is a RAM of
// MAX_POINTS words and needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module spherical_flip_transform import sft_pkg::*; #(
	parameter int MAX_POINTS = 4096
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	sft_in_if.sink                     in_ch,
	sft_out_if.source                  out_ch,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	sft_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.cmd     (cmd),
		.sts     (sts)
	);

	sft_dpath #(
		.MAX_POINTS(MAX_POINTS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.operation    (in_ch.operation),
		.point_x      (in_ch.point_x),
		.point_y      (in_ch.point_y),
		.point_z      (in_ch.point_z),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_ch.valid),
		.out_ready    (out_ch.ready),
		.flipped_x    (out_ch.flipped_x),
		.flipped_y    (out_ch.flipped_y),
		.flipped_z    (out_ch.flipped_z),
		.is_viewpoint (out_ch.is_viewpoint),
		.last_of_cloud(out_ch.last_of_cloud),
		.status       (out_ch.status)
	);

endmodule

`default_nettype wire

@@ rtl/core/sft_checker.sv @@
// ----------------------------------------------------------------------------
// sft_checker
// Port-level checks of the spherical flip transform, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sft_checker import sft_pkg::*; (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_ready,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic signed [OUT_W-1:0] flipped_x,
	input wire logic signed [OUT_W-1:0] flipped_y,
	input wire logic signed [OUT_W-1:0] flipped_z,
	input wire logic                    is_viewpoint,
	input wire logic                    last_of_cloud,
	input wire logic [STATUS_W-1:0]     status
);

	// hold a stalled output word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	// drop ready after taking a word
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a word is in work");

	// zero coordinates on any error status
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != ST_OK) |->
		(flipped_x == '0) && (flipped_y == '0) && (flipped_z == '0) &&
		!is_viewpoint && !last_of_cloud)
		else $error("error word carries data");

	// origin word is last, ok and zero
	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_viewpoint |->
		last_of_cloud && (status == ST_OK) && (flipped_x == '0) &&
		(flipped_y == '0) && (flipped_z == '0))
		else $error("malformed origin word");

endmodule

bind spherical_flip_transform sft_checker u_sft_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.flipped_x    (out_ch.flipped_x),
	.flipped_y    (out_ch.flipped_y),
	.flipped_z    (out_ch.flipped_z),
	.is_viewpoint (out_ch.is_viewpoint),
	.last_of_cloud(out_ch.last_of_cloud),
	.status       (out_ch.status)
);

`default_nettype wire

@@ verif/spherical_flip_transform_tb.sv @@
// ----------------------------------------------------------------------------
// spherical_flip_transform_tb
// Self-checking bench for the spherical flip transform. A short table of
// directed words covers the extremes and the special cases, then random
// clouds of loads, flips and transforms run under several viewpoints, gains
// and idle patterns. Every result is checked against a typed expected word
// from the table or an in-bench model of the flip arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module spherical_flip_transform_tb;
	import sft_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 4096;
	localparam int DRAIN_CYCLES = 150;
	localparam logic [127:0] POS_SAT = (128'd1 << 55) - 1;
	localparam logic [127:0] NEG_SAT = 128'd1 << 55;

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic signed [OUT_W-1:0] z;
		logic                    vp;
		logic                    last;
		logic [STATUS_W-1:0]     st;
	} flip_word_t;

	typedef struct packed {
		op_t                       op;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic                      typed;
		flip_word_t                want;
	} dir_row_t;

	localparam flip_word_t W_ORIGIN  = '{'0, '0, '0, 1'b1, 1'b1, ST_OK};
	localparam flip_word_t W_PAST    = '{'0, '0, '0, 1'b0, 1'b0, ST_EXHAUSTED};
	localparam flip_word_t W_NORAD   = '{'0, '0, '0, 1'b0, 1'b0, ST_NO_RADIUS};
	localparam flip_word_t W_ZERO    = '{'0, '0, '0, 1'b0, 1'b0, ST_ZERO_DIST};
	localparam flip_word_t W_NONE    = '{'0, '0, '0, 1'b0, 1'b0, ST_OK};
	localparam logic signed [COORD_W-1:0] CMAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] CMIN = -24'sh800000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sft_in_if  in_ch ();
	sft_out_if out_ch ();

	spherical_flip_transform dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// model state
	logic signed [COORD_W-1:0] view_x, view_y, view_z;
	logic [GAIN_W-1:0]         gain;
	logic signed [COORD_W-1:0] pts_x [STORE_DEPTH];
	logic signed [COORD_W-1:0] pts_y [STORE_DEPTH];
	logic signed [COORD_W-1:0] pts_z [STORE_DEPTH];
	logic [NORM_W-1:0]         pts_n [STORE_DEPTH];
	logic [NORM_W-1:0]         peak_norm;
	logic [RADIUS_W-1:0]       sphere_r;
	logic                      sphere_r_ok;
	int                        n_points;
	int                        next_pt;
	logic                      flipping;

	flip_word_t expected_words[$];
	int         errors;
	int         idle_pct;
	int         stall_pct;
	int         hold_left;

	dir_row_t dir_tab[21] = '{
		'{OP_XFORM, 24'sd1, 24'sd2, 24'sd3, 1'b1, W_NORAD},
		'{OP_NOP, 24'sd9, 24'sd9, 24'sd9, 1'b0, W_NONE},
		'{OP_FLIP, 24'sd0, 24'sd0, 24'sd0, 1'b1, W_ORIGIN},
		'{OP_FLIP, 24'sd0, 24'sd0, 24'sd0, 1'b1, W_PAST},
		'{OP_XFORM, 24'sd0, 24'sd0, 24'sd0, 1'b1, W_ZERO},
		'{OP_LOAD, CMAX, CMAX, CMAX, 1'b0, W_NONE},
		'{OP_LOAD, CMIN, CMIN, CMIN, 1'b0, W_NONE},
		'{OP_LOAD, 24'sd0, 24'sd0, 24'sd0, 1'b0, W_NONE},
		'{OP_LOAD, 24'sd1, -24'sd1, 24'sd0, 1'b0, W_NONE},
		'{OP_FLIP, 24'sd0, 24'sd0, 24'sd0, 1'b0, W_NONE},
		'{OP_FLIP, 24'sd0, 24'sd0, 24'sd0, 1'b0, W_NONE},
		'{OP_FLIP, 24'sd0, 24'sd0, 24'sd0, 1'b1, W_ZERO},
		'{OP_FLIP, 24'sd0, 24'sd0, 24'sd0, 1'b0, W_NONE},
		'{OP_FLIP, 24'sd0, 24'sd0, 24'sd0, 1'b1, W_ORIGIN},
		'{OP_FLIP, 24'sd0, 24'sd0, 24'sd0, 1'b1, W_PAST},
		'{OP_XFORM, CMIN, CMAX, 24'sd1, 1'b0, W_NONE},
		'{OP_LOAD, 24'sd5, 24'sd0, 24'sd0, 1'b0, W_NONE},
		'{OP_FLIP, 24'sd0, 24'sd0, 24'sd0, 1'b0, W_NONE},
		'{OP_LOAD, 24'sd7, 24'sd7, 24'sd7, 1'b0, W_NONE},
		'{OP_FLIP, 24'sd0, 24'sd0, 24'sd0, 1'b0, W_NONE},
		'{OP_FLIP, 24'sd0, 24'sd0, 24'sd0, 1'b1, W_ORIGIN}
	};

	// clock
	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [NORM_W-1:0] dist_q8(logic signed [COORD_W-1:0] x,
		logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
		longint sx, sy, sz;
		sx = x;
		sy = y;
		sz = z;
		return NORM_W'(int_sqrt(64'(sx * sx + sy * sy + sz * sz) << 16));
	endfunction

	// p * 256 * (2R - n) / n, truncated toward zero, saturated to 56 bits
	function automatic logic signed [OUT_W-1:0] flip_axis(logic signed [COORD_W-1:0] p,
		logic [NORM_W-1:0] n, logic [RADIUS_W-1:0] r);
		logic signed [50:0] d;
		logic [127:0]       a, b, q;
		int                 pi;
		logic               neg;
		if (n == 0)
			return '0;
		pi = p;
		d = $signed({2'b00, r, 1'b0}) - $signed({19'd0, n});
		a = 128'(pi < 0 ? -pi : pi) << 8;
		b = 128'(d < 0 ? -d : d);
		q = (a * b) / 128'(n);
		neg = (pi < 0) != (d < 0);
		if (neg) begin
			if (q > NEG_SAT)
				q = NEG_SAT;
			return OUT_W'(-q);
		end
		if (q > POS_SAT)
			q = POS_SAT;
		return OUT_W'(q);
	endfunction

	function automatic flip_word_t flip_point(logic signed [COORD_W-1:0] x,
		logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z, logic [NORM_W-1:0] n);
		flip_word_t w;
		w = W_NONE;
		if (n == 0) begin
			w.st = ST_ZERO_DIST;
		end else begin
			w.x = flip_axis(x, n, sphere_r);
			w.y = flip_axis(y, n, sphere_r);
			w.z = flip_axis(z, n, sphere_r);
		end
		return w;
	endfunction

	// advance the model by one accepted word
	task automatic flip_model(op_t op, logic signed [COORD_W-1:0] px,
		logic signed [COORD_W-1:0] py, logic signed [COORD_W-1:0] pz,
		output bit has, output flip_word_t w);
		logic signed [COORD_W-1:0] x, y, z;
		logic [NORM_W-1:0]         n;
		x = rel_coord(px, view_x);
		y = rel_coord(py, view_y);
		z = rel_coord(pz, view_z);
		has = 1'b0;
		w = W_NONE;
		case (op)
			OP_LOAD: begin
				if (flipping) begin
					flipping = 1'b0;
					n_points = 0;
					next_pt = 0;
					peak_norm = '0;
				end
				if (n_points < STORE_DEPTH) begin
					n = dist_q8(x, y, z);
					pts_x[n_points] = x;
					pts_y[n_points] = y;
					pts_z[n_points] = z;
					pts_n[n_points] = n;
					if (n > peak_norm)
						peak_norm = n;
					n_points++;
				end
			end
			OP_FLIP: begin
				has = 1'b1;
				if (!flipping) begin
					sphere_r = RADIUS_W'((64'(gain) * 64'(peak_norm)) >> 16);
					sphere_r_ok = 1'b1;
					flipping = 1'b1;
					next_pt = 0;
				end
				if (next_pt < n_points) begin
					w = flip_point(pts_x[next_pt], pts_y[next_pt], pts_z[next_pt],
						pts_n[next_pt]);
					next_pt++;
				end else if (next_pt == n_points) begin
					w = W_ORIGIN;
					next_pt++;
				end else begin
					w = W_PAST;
				end
			end
			OP_XFORM: begin
				has = 1'b1;
				if (!sphere_r_ok)
					w = W_NORAD;
				else
					w = flip_point(x, y, z, dist_q8(x, y, z));
			end
			default: ;
		endcase
	endtask

	// append one word to the tail of the expected queue
	task automatic queue_expected(flip_word_t w);
		expected_words.insert(expected_words.size(), w);
	endtask

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
		errors++;
	endtask

	// check each delivered word against the oldest expectation
	always @(posedge clk) begin
		flip_word_t w;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", 64'(out_ch.status), 64'd0);
			end else begin
				w = expected_words.pop_front();
				if (out_ch.flipped_x !== w.x)
					report_mismatch("flipped_x", 64'(out_ch.flipped_x), 64'(w.x));
				if (out_ch.flipped_y !== w.y)
					report_mismatch("flipped_y", 64'(out_ch.flipped_y), 64'(w.y));
				if (out_ch.flipped_z !== w.z)
					report_mismatch("flipped_z", 64'(out_ch.flipped_z), 64'(w.z));
				if (out_ch.is_viewpoint !== w.vp)
					report_mismatch("is_viewpoint", 64'(out_ch.is_viewpoint), 64'(w.vp));
				if (out_ch.last_of_cloud !== w.last)
					report_mismatch("last_of_cloud", 64'(out_ch.last_of_cloud), 64'(w.last));
				if (out_ch.status !== w.st)
					report_mismatch("status", 64'(out_ch.status), 64'(w.st));
			end
		end
	end

	// stall the output side, with an optional long hold
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ch.ready = 1'b0;
			hold_left--;
		end else begin
			out_ch.ready = ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_word(op_t op, logic signed [COORD_W-1:0] x,
		logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
		logic typed, flip_word_t want);
		bit         has;
		flip_word_t w;
		while ($urandom_range(99) < idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.operation = op;
		in_ch.point_x = x;
		in_ch.point_y = y;
		in_ch.point_z = z;
		do
			@(posedge clk);
		while (!in_ch.ready);
		flip_model(op, x, y, z, has, w);
		if (has)
			queue_expected(typed ? want : w);
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	task automatic drain();
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_VIEW_X: view_x = data[COORD_W-1:0];
			CFG_VIEW_Y: view_y = data[COORD_W-1:0];
			CFG_VIEW_Z: view_z = data[COORD_W-1:0];
			default:    gain = data;
		endcase
	endtask

	task automatic set_view(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
		logic signed [COORD_W-1:0] z, logic [GAIN_W-1:0] g);
		cfg_write(CFG_VIEW_X, 32'(x));
		cfg_write(CFG_VIEW_Y, 32'(y));
		cfg_write(CFG_VIEW_Z, 32'(z));
		cfg_write(CFG_GAIN, g);
	endtask

	function automatic logic signed [COORD_W-1:0] rnd_coord();
		case ($urandom_range(9))
			0:       return CMAX;
			1:       return CMIN;
			2, 3:    return COORD_W'(int'($urandom_range(400)) - 200);
			default: return COORD_W'($urandom);
		endcase
	endfunction

	// one random cloud: loads, then flips up to or past the end, mixed with transforms
	task automatic run_cloud(inout int done);
		int                        pts, flips, k;
		logic signed [COORD_W-1:0] x, y, z;
		pts = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
		flips = pts + 1 + $urandom_range(0, 2);
		for (k = 0; k < pts + flips; k++) begin
			if ($urandom_range(19) == 0) begin
				send_word(OP_NOP, rnd_coord(), rnd_coord(), rnd_coord(), 1'b0, W_NONE);
				continue;
			end
			if ($urandom_range(9) == 0) begin
				x = view_x;
				y = view_y;
				z = view_z;
			end else begin
				x = rnd_coord();
				y = rnd_coord();
				z = rnd_coord();
			end
			if ($urandom_range(7) == 0)
				send_word(OP_XFORM, x, y, z, 1'b0, W_NONE);
			else if (k < pts)
				send_word(OP_LOAD, x, y, z, 1'b0, W_NONE);
			else if (k > pts && $urandom_range(29) == 0)
				return;
			else
				send_word(OP_FLIP, x, y, z, 1'b0, W_NONE);
			done++;
		end
	endtask

	initial begin
		int done, ph, k;
		errors = 0;
		idle_pct = 0;
		stall_pct = 0;
		hold_left = 0;
		cfg_we = 1'b0;
		cfg_index = CFG_VIEW_X;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.operation = OP_NOP;
		in_ch.point_x = '0;
		in_ch.point_y = '0;
		in_ch.point_z = '0;
		out_ch.ready = 1'b0;
		view_x = '0;
		view_y = '0;
		view_z = '0;
		gain = GAIN_RESET;
		peak_norm = '0;
		sphere_r = '0;
		sphere_r_ok = 1'b0;
		n_points = 0;
		next_pt = 0;
		flipping = 1'b0;

		// hold reset, then release on a falling edge
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// walk the directed table at reset settings
		foreach (dir_tab[i])
			send_word(dir_tab[i].op, dir_tab[i].x, dir_tab[i].y, dir_tab[i].z,
				dir_tab[i].typed, dir_tab[i].want);

		// flip, then restart and fill the store past its depth, then flip once and transform
		drain();
		set_view(24'sd1000, -24'sd1000, 24'sd0, GAIN_RESET);
		send_word(OP_FLIP, '0, '0, '0, 1'b0, W_NONE);
		for (k = 0; k <= STORE_DEPTH; k++)
			send_word(OP_LOAD, rnd_coord(), rnd_coord(), rnd_coord(), 1'b0, W_NONE);
		send_word(OP_FLIP, '0, '0, '0, 1'b0, W_NONE);
		send_word(OP_XFORM, rnd_coord(), rnd_coord(), rnd_coord(), 1'b0, W_NONE);

		// random phases with different settings and idle patterns
		for (ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: begin
					set_view(CMAX, CMIN, CMAX, 32'd0);
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					set_view(CMIN, CMAX, CMIN, 32'hFFFF_FFFF);
					idle_pct = 73;
					stall_pct = 0;
				end
				2: begin
					set_view(rnd_coord(), rnd_coord(), rnd_coord(), 32'd655360);
					idle_pct = 0;
					stall_pct = 73;
					hold_left = 600;
				end
				default: begin
					set_view(rnd_coord(), rnd_coord(), rnd_coord(), $urandom);
					idle_pct = 33;
					stall_pct = 33;
				end
			endcase
			done = 0;
			while (done < 500)
				run_cloud(done);
		end

		drain();
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// timeout
	initial begin
		#5000000;
		$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
